@@ hw/rtl/stb_pkg.sv @@
// shared types and constants for the software timer bank
package stb_pkg;

  // event codes of a result word
  localparam logic [1:0] EV_CREATED = 2'd0;
  localparam logic [1:0] EV_FAILED  = 2'd1;
  localparam logic [1:0] EV_EXPIRED = 2'd2;

  // timer modes
  localparam logic [3:0] MODE_ONESHOT  = 4'd1;
  localparam logic [3:0] MODE_PERIODIC = 4'd2;
  localparam logic [3:0] MODE_MAX      = 4'd10;

  // input word kinds
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_CREATE = 1'b1;

  // configuration register indexes
  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_MS     = 1'b1;

  localparam logic [9:0] MS_RESET = 10'd10;

  // restoring divider: one quotient bit per step
  localparam int DIV_STEPS = 32;

  typedef struct packed {
    logic        kind;
    logic [31:0] period_ms;
    logic [3:0]  mode;
    logic [15:0] owner;
  } stb_in_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [4:0]  slot;
    logic [15:0] owner_out;
    logic        last;
    logic [63:0] tick_count;
    logic [63:0] time_ms;
  } stb_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_WRITE,
    S_OKPUSH,
    S_FAILPUSH,
    S_TRD,
    S_TPROC,
    S_TFIN
  } stb_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic tick_start;
    logic idx_clr;
    logic idx_inc;
    logic div_start;
    logic slot_write;
    logic mem_rd;
    logic tproc_go;
    logic push_ok;
    logic push_fail;
    logic push_final;
  } stb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_kind;
    logic in_mode_ok;
    logic enable;
    logic used_at_idx;
    logic idx_last;
    logic div_done;
    logic tstall;
    logic pend_valid;
    logic out_free;
  } stb_status_t;

endpackage

@@ hw/rtl/stb_div.sv @@
// restoring divider for the tick count of a new timer
module stb_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [9:0]  divisor,
  output logic        done,
  output logic [31:0] quotient
);
  import stb_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic [31:0]      q_r, q_nxt;
  logic [9:0]       rem_r, rem_nxt;
  logic [9:0]       d_r, d_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [10:0]      trial;
  logic             stepping;

  assign stepping = busy_r && (cnt_r != CNT_W'(DIV_STEPS));
  assign trial    = {rem_r, q_r[31]};

  // one quotient bit per cycle
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (stepping) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = 10'(trial - {1'b0, d_r});
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial[9:0];
        q_nxt   = {q_r[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done     = busy_r && (cnt_r == CNT_W'(DIV_STEPS));
  assign quotient = q_r;

endmodule

@@ hw/rtl/stb_ctrl.sv @@
// controller state machine of the timer bank
module stb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  stb_pkg::stb_status_t st,
  output stb_pkg::stb_cmd_t    cmd
);
  import stb_pkg::*;

  stb_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (st.in_kind == KIND_CREATE) begin
            state_nxt = st.in_mode_ok ? S_SCAN : S_FAILPUSH;
          end else if (st.enable) begin
            state_nxt = S_TRD;
          end
        end
      end
      S_SCAN: begin
        if (!st.used_at_idx) begin
          state_nxt = S_DIV;
        end else if (st.idx_last) begin
          state_nxt = S_FAILPUSH;
        end
      end
      S_DIV: begin
        if (st.div_done) state_nxt = S_WRITE;
      end
      S_WRITE:    state_nxt = S_OKPUSH;
      S_OKPUSH: begin
        if (st.out_free) state_nxt = S_IDLE;
      end
      S_FAILPUSH: begin
        if (st.out_free) state_nxt = S_IDLE;
      end
      S_TRD:      state_nxt = S_TPROC;
      S_TPROC: begin
        if (!st.tstall) state_nxt = st.idx_last ? S_TFIN : S_TRD;
      end
      S_TFIN: begin
        if (!st.pend_valid || st.out_free) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept  = 1'b1;
          cmd.idx_clr = 1'b1;
          if (st.in_kind == KIND_TICK && st.enable) cmd.tick_start = 1'b1;
        end
      end
      S_SCAN: begin
        if (!st.used_at_idx) begin
          cmd.div_start = 1'b1;
        end else if (!st.idx_last) begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_WRITE:    cmd.slot_write = 1'b1;
      S_OKPUSH:   cmd.push_ok = st.out_free;
      S_FAILPUSH: cmd.push_fail = st.out_free;
      S_TRD:      cmd.mem_rd = 1'b1;
      S_TPROC: begin
        if (!st.tstall) begin
          cmd.tproc_go = 1'b1;
          cmd.idx_inc  = !st.idx_last;
        end
      end
      S_TFIN:     cmd.push_final = st.pend_valid && st.out_free;
      default:    cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/stb_dp.sv @@
// datapath of the timer bank: slot store, counters, result registers
module stb_dp #(
  parameter int NUM_SLOTS  = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  stb_pkg::stb_in_t     in_data,
  output stb_pkg::stb_out_t    out_data,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [9:0]          cfg_wdata,
  input  stb_pkg::stb_cmd_t    cmd,
  output stb_pkg::stb_status_t st
);
  import stb_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [63:0] COUNT_MASK64 = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - COUNT_BITS);

  // configuration
  logic       enable_r;
  logic [9:0] mpt_r;
  logic [9:0] mpt_eff;

  // latched item and counters
  stb_in_t     item_r;
  logic [63:0] ticks_r, millis_r;
  logic [IDX_W-1:0] idx_r;
  logic [NUM_SLOTS-1:0] used_r;

  // slot store
  logic [3:0]            mode_mem [NUM_SLOTS];
  logic [COUNT_BITS-1:0] rem_mem  [NUM_SLOTS];
  logic [COUNT_BITS-1:0] rel_mem  [NUM_SLOTS];
  logic [15:0]           own_mem  [NUM_SLOTS];
  logic [3:0]            rd_mode_r;
  logic [COUNT_BITS-1:0] rd_rem_r, rd_rel_r;
  logic [15:0]           rd_own_r;

  // pending expiry and output register
  logic       pend_valid_r;
  logic [4:0] pend_slot_r;
  logic [15:0] pend_owner_r;
  logic       out_valid_r;
  stb_out_t   out_r;

  logic        out_free;
  logic        active, hit;
  logic [COUNT_BITS-1:0] new_rem, reload;
  logic [31:0] dividend, quotient;
  logic [63:0] quo64, sat64;
  logic        div_done;

  assign mpt_eff  = (mpt_r == 10'd0) ? 10'd1 : mpt_r;
  assign out_free = !out_valid_r || out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      mpt_r    <= MS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE: enable_r <= cfg_wdata[0];
        CFG_MS:     mpt_r    <= cfg_wdata;
        default:    enable_r <= enable_r;
      endcase
    end
  end

  // period clamp and division
  assign dividend = (item_r.period_ms < {22'd0, mpt_eff}) ? {22'd0, mpt_eff}
                                                           : item_r.period_ms;

  stb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (mpt_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  // saturate the reload to the count width
  assign quo64  = {32'd0, quotient};
  assign sat64  = (quo64 > COUNT_MASK64) ? COUNT_MASK64 : quo64;
  assign reload = sat64[COUNT_BITS-1:0];

  // slot decrement and periodic reload during a tick walk
  assign active  = used_r[idx_r] && (rd_rem_r != '0);
  assign hit     = active && (rd_rem_r == COUNT_BITS'(1));
  assign new_rem = (hit && rd_mode_r == MODE_PERIODIC) ? rd_rel_r
                                                       : rd_rem_r - COUNT_BITS'(1);

  // item, index, counters, used marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r  <= '0;
      millis_r <= '0;
      idx_r    <= '0;
      used_r   <= '0;
    end else begin
      if (cmd.tick_start) begin
        ticks_r  <= ticks_r + 64'd1;
        millis_r <= millis_r + {54'd0, mpt_eff};
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cmd.slot_write) used_r[idx_r] <= 1'b1;
    end
    if (cmd.accept) item_r <= in_data;
  end

  // slot store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.slot_write) begin
      mode_mem[idx_r] <= item_r.mode;
      rem_mem[idx_r]  <= reload;
      rel_mem[idx_r]  <= reload;
      own_mem[idx_r]  <= item_r.owner;
    end else if (cmd.tproc_go && active) begin
      rem_mem[idx_r]  <= new_rem;
    end
    if (cmd.mem_rd) begin
      rd_mode_r <= mode_mem[idx_r];
      rd_rem_r  <= rem_mem[idx_r];
      rd_rel_r  <= rel_mem[idx_r];
      rd_own_r  <= own_mem[idx_r];
    end
  end

  // pending expiry and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.push_ok || cmd.push_fail || cmd.push_final ||
          (cmd.tproc_go && hit && pend_valid_r)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.tproc_go && hit) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.push_final) begin
        pend_valid_r <= 1'b0;
      end
    end
    if (cmd.tproc_go && hit) begin
      pend_slot_r  <= 5'(idx_r);
      pend_owner_r <= rd_own_r;
    end
    // counters are captured only when a word is loaded
    if (cmd.push_ok) begin
      out_r.event_res  <= EV_CREATED;
      out_r.slot       <= 5'(idx_r);
      out_r.owner_out  <= item_r.owner;
      out_r.last       <= 1'b1;
      out_r.tick_count <= ticks_r;
      out_r.time_ms    <= millis_r;
    end else if (cmd.push_fail) begin
      out_r.event_res  <= EV_FAILED;
      out_r.slot       <= 5'd0;
      out_r.owner_out  <= item_r.owner;
      out_r.last       <= 1'b1;
      out_r.tick_count <= ticks_r;
      out_r.time_ms    <= millis_r;
    end else if (cmd.push_final || (cmd.tproc_go && hit && pend_valid_r)) begin
      out_r.event_res  <= EV_EXPIRED;
      out_r.slot       <= pend_slot_r;
      out_r.owner_out  <= pend_owner_r;
      out_r.last       <= cmd.push_final;
      out_r.tick_count <= ticks_r;
      out_r.time_ms    <= millis_r;
    end else if (out_free) begin
      out_r.event_res <= out_r.event_res;
    end
  end

  // status to the controller
  always_comb begin
    st             = '0;
    st.in_kind     = in_data.kind;
    st.in_mode_ok  = (in_data.mode >= MODE_ONESHOT) && (in_data.mode <= MODE_MAX);
    st.enable      = enable_r;
    st.used_at_idx = used_r[idx_r];
    st.idx_last    = (idx_r == IDX_W'(NUM_SLOTS - 1));
    st.div_done    = div_done;
    st.tstall      = hit && pend_valid_r && !out_free;
    st.pend_valid  = pend_valid_r;
    st.out_free    = out_free;
  end

  assign out_valid = out_valid_r;

  always_comb begin
    out_data = out_r;
    if (!out_valid_r) out_data = out_r;
  end

  // a result is loaded only when the output register can take it
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_ok || cmd.push_fail || cmd.push_final) |-> out_free)
    else $error("result loaded over a waiting word");

  // a second expiry never overwrites the pending one unsent
  a_pend_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tproc_go && hit && pend_valid_r) |-> out_free)
    else $error("pending expiry lost");

  // a new timer only claims a free slot
  a_claim_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.slot_write |-> !used_r[idx_r])
    else $error("used slot claimed again");

  // the final expiry leaves nothing pending
  a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_final |=> !pend_valid_r)
    else $error("pending expiry left after final word");

endmodule

@@ hw/rtl/software_timer_bank_top.sv @@
// top level of the software timer bank
// create word: states scan (for a free slot), divide, write and result push; the next word is
//   taken once the result is pushed; bad mode or full bank: a failure result, no divide
// tick word: each slot is read, then updated; the final expiry, if any, is pushed after the walk,
//   and the next word is taken after that; disabled tick: taken, no walk; waiting results stall
// synchronous active-low reset clears counters, used marks and control; slot store not cleared
module software_timer_bank_top #(
  parameter int NUM_SLOTS  = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  stb_pkg::stb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output stb_pkg::stb_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [9:0]        cfg_wdata
);
  import stb_pkg::*;

  stb_cmd_t    cmd;
  stb_status_t st;

  // sequencer
  stb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // slot store and counters
  stb_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

@@ tb/stb_scoreboard.sv @@
// checker for the software timer bank: mirrors config, predicts result words, compares
module stb_scoreboard #(
  parameter int NUM_SLOTS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  stb_pkg::stb_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  stb_pkg::stb_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [9:0]        cfg_wdata,
  output int                mismatches,
  output int                pending
);
  import stb_pkg::*;

  // mirrored registers and timer state
  logic        enable_q;
  logic [9:0]  ms_q;
  logic [63:0] ticks_q;
  logic [63:0] millis_q;
  logic        used_q    [NUM_SLOTS];
  logic [3:0]  mode_q    [NUM_SLOTS];
  logic [31:0] remain_q  [NUM_SLOTS];
  logic [31:0] reload_q  [NUM_SLOTS];
  logic [15:0] owner_q   [NUM_SLOTS];

  stb_out_t timer_events[$];

  assign pending = timer_events.size();

  // build one result word from the current counters
  function automatic stb_out_t make_event(logic [1:0] ev, logic [4:0] slot,
                                          logic [15:0] owner, logic last);
    stb_out_t r;
    r.event_res  = ev;
    r.slot       = slot;
    r.owner_out  = owner;
    r.last       = last;
    r.tick_count = ticks_q;
    r.time_ms    = millis_q;
    return r;
  endfunction

  // advance the timer bank by one input word and queue what it causes
  task automatic apply_timer_word(stb_in_t w);
    logic [31:0] mpt;
    logic [31:0] period;
    int          free_slot;
    int          first_idx;
    stb_out_t    ev;
    mpt = (ms_q == 10'd0) ? 32'd1 : {22'd0, ms_q};
    if (w.kind == KIND_CREATE) begin
      free_slot = -1;
      if (w.mode >= MODE_ONESHOT && w.mode <= MODE_MAX) begin
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
          if (!used_q[i]) free_slot = i;
        end
      end
      if (free_slot < 0) begin
        timer_events.push_back(make_event(EV_FAILED, 5'd0, w.owner, 1'b1));
      end else begin
        period = (w.period_ms < mpt) ? mpt : w.period_ms;
        used_q[free_slot]   = 1'b1;
        mode_q[free_slot]   = w.mode;
        reload_q[free_slot] = period / mpt;
        remain_q[free_slot] = period / mpt;
        owner_q[free_slot]  = w.owner;
        timer_events.push_back(make_event(EV_CREATED, free_slot[4:0], w.owner, 1'b1));
      end
    end else if (enable_q) begin
      ticks_q   = ticks_q + 64'd1;
      millis_q  = millis_q + {32'd0, mpt};
      first_idx = timer_events.size();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (used_q[i] && remain_q[i] != 32'd0) begin
          remain_q[i] = remain_q[i] - 32'd1;
          if (remain_q[i] == 32'd0) begin
            timer_events.push_back(make_event(EV_EXPIRED, i[4:0], owner_q[i], 1'b0));
            if (mode_q[i] == MODE_PERIODIC) remain_q[i] = reload_q[i];
          end
        end
      end
      // final expiry of this tick carries last
      if (timer_events.size() > first_idx) begin
        ev = timer_events[$];
        ev.last = 1'b1;
        timer_events[timer_events.size() - 1] = ev;
      end
    end
  endtask

  // watch config, input and result channels
  always @(posedge clk) begin
    stb_out_t exp_word;
    if (!rst_n) begin
      enable_q   = 1'b0;
      ms_q       = MS_RESET;
      ticks_q    = '0;
      millis_q   = '0;
      mismatches = 0;
      for (int i = 0; i < NUM_SLOTS; i++) used_q[i] = 1'b0;
      timer_events.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ENABLE) enable_q = cfg_wdata[0];
        else ms_q = cfg_wdata;
      end
      if (out_valid && out_ready) begin
        if (timer_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word %h", out_data);
        end else begin
          exp_word = timer_events.pop_front();
          if (exp_word.event_res !== out_data.event_res ||
              exp_word.slot !== out_data.slot ||
              exp_word.owner_out !== out_data.owner_out ||
              exp_word.last !== out_data.last ||
              exp_word.tick_count !== out_data.tick_count ||
              exp_word.time_ms !== out_data.time_ms) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: ev %0d/%0d slot %0d/%0d owner %h/%h",
                       exp_word.event_res, out_data.event_res,
                       exp_word.slot, out_data.slot,
                       exp_word.owner_out, out_data.owner_out,
                       " last %b/%b ticks %0d/%0d ms %0d/%0d",
                       exp_word.last, out_data.last,
                       exp_word.tick_count, out_data.tick_count,
                       exp_word.time_ms, out_data.time_ms);
          end
        end
      end
      if (in_valid && in_ready) apply_timer_word(in_data);
    end
  end

endmodule

@@ tb/software_timer_bank_top_tb.sv @@
// stimulus and verdict for the software timer bank
module software_timer_bank_top_tb;
  import stb_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  stb_in_t    in_data;
  logic       out_valid;
  logic       out_ready;
  stb_out_t   out_data;
  logic       cfg_we;
  logic       cfg_index;
  logic [9:0] cfg_wdata;
  int         mismatches;
  int         pending;

  int         send_idle_pct;
  int         recv_stall_pct;
  logic       hold_off;
  logic [9:0] cur_ms;

  software_timer_bank_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  stb_scoreboard u_scoreboard (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20000000;
    $display("software_timer_bank_top verification failed");
    $finish;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // offer one word, with random idle cycles ahead of it
  task automatic send_word(stb_in_t w);
    logic rdy;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  // wait for every expected word, then for a tick walk to finish
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [9:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == CFG_MS) cur_ms = value;
  endtask

  function automatic stb_in_t tick_word();
    stb_in_t w;
    w           = '0;
    w.kind      = KIND_TICK;
    w.period_ms = $urandom;
    w.mode      = 4'($urandom);
    w.owner     = 16'($urandom);
    return w;
  endfunction

  function automatic stb_in_t create_word(logic [31:0] period, logic [3:0] mode,
                                          logic [15:0] owner);
    stb_in_t w;
    w.kind      = KIND_CREATE;
    w.period_ms = period;
    w.mode      = mode;
    w.owner     = owner;
    return w;
  endfunction

  // random create with mostly short periods so expiries keep coming
  function automatic stb_in_t random_create();
    logic [31:0] period;
    logic [3:0]  mode;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) period = $urandom;
    else period = $urandom_range(0, 12) * ((cur_ms == 0) ? 1 : cur_ms) + $urandom_range(0, 3);
    pick = $urandom_range(0, 99);
    if (pick < 40) mode = MODE_PERIODIC;
    else if (pick < 70) mode = MODE_ONESHOT;
    else if (pick < 85) mode = 4'($urandom_range(3, 10));
    else if (pick < 90) mode = 4'd0;
    else mode = 4'($urandom_range(11, 15));
    return create_word(period, mode, 16'($urandom_range(0, 65535)));
  endfunction

  task automatic random_phase(int count, int create_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < create_pct) send_word(random_create());
      else send_word(tick_word());
    end
  endtask

  initial begin
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_ENABLE;
    cfg_wdata      = '0;
    hold_off       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cur_ms         = MS_RESET;
    rst_n          = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: disabled tick, extremes of fields, bad modes
    send_word(tick_word());
    send_word(create_word(32'd0, MODE_ONESHOT, 16'h0000));
    send_word(create_word(32'd25, MODE_PERIODIC, 16'hffff));
    send_word(create_word(32'd30, 4'd0, 16'h1234));
    send_word(create_word(32'd30, 4'd15, 16'hffff));
    send_word(create_word(32'd30, 4'd11, 16'h0001));
    send_word(create_word(32'hffffffff, MODE_MAX, 16'h8000));
    send_word(create_word(32'd9, 4'd3, 16'h5a5a));
    drain_results();
    write_cfg(CFG_ENABLE, 10'd1);
    repeat (4) send_word(tick_word());
    drain_results();
    // zero ms per tick acts as one
    write_cfg(CFG_MS, 10'd0);
    send_word(create_word(32'd2, MODE_PERIODIC, 16'h00aa));
    repeat (3) send_word(tick_word());
    drain_results();
    write_cfg(CFG_MS, 10'd1000);
    send_word(create_word(32'd999, MODE_PERIODIC, 16'h0bb0));
    send_word(create_word(32'd2500, MODE_ONESHOT, 16'h0cc0));
    repeat (3) send_word(tick_word());
    drain_results();

    // random: no idling
    write_cfg(CFG_MS, 10'd1);
    random_phase(110, 15);
    // receiver holds off for a long stretch while words keep coming
    fork
      begin
        hold_off <= 1'b1;
        repeat (600) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    random_phase(20, 30);
    drain_results();

    // sender idling
    write_cfg(CFG_MS, 10'($urandom_range(1, 1000)));
    send_idle_pct = 76;
    random_phase(100, 15);
    drain_results();

    // disabled stretch, creates still handled
    write_cfg(CFG_ENABLE, 10'd0);
    random_phase(10, 30);
    drain_results();
    write_cfg(CFG_ENABLE, 10'd1);

    // receiver stalling
    write_cfg(CFG_MS, 10'd10);
    send_idle_pct  = 0;
    recv_stall_pct = 76;
    random_phase(100, 15);
    drain_results();

    // both idling, then fill the bank past full
    write_cfg(CFG_MS, 10'd1000);
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    random_phase(60, 15);
    random_phase(60, 60);
    drain_results();

    if (mismatches == 0 && pending == 0) begin
      $display("software_timer_bank_top verification clean");
    end else begin
      $display("software_timer_bank_top verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/stb_pkg.sv
hw/rtl/stb_div.sv
hw/rtl/stb_ctrl.sv
hw/rtl/stb_dp.sv
hw/rtl/software_timer_bank_top.sv
tb/stb_scoreboard.sv
tb/software_timer_bank_top_tb.sv
